// ===== design/r2fft_pkg.sv =====
// shared types and constants for the radix-2 fft engine
// no dependencies
package r2fft_pkg;

    localparam int MaxLog2 = 6;
    localparam int MaxPoints = 64;
    localparam int SampleW = 16;
    localparam int BinW = 23;
    localparam int AddrW = 6;
    localparam int CntW = 7;
    localparam int CfgW = 3;

    localparam logic [0:0] CFG_LOG2_POINTS = 1'b0;
    localparam logic [0:0] CFG_INVERSE = 1'b1;

    localparam logic signed [BinW-1:0] SAT_MAX = 23'sd4194303;
    localparam logic signed [BinW-1:0] SAT_MIN = -23'sd4194304;

    // one loaded sample handed from the front to the back
    typedef struct packed {
        logic signed [SampleW-1:0] re;
        logic signed [SampleW-1:0] im;
        logic                      last;
        logic [2:0]                lg;
        logic                      inv;
    } smp_t;

    typedef logic [15:0] coef_t;

    // quarter sine table, 1.0 held as 32767
    function automatic logic [15:0] qsin(input logic [4:0] k);
        logic [15:0] v;
        begin
            case (k)
                5'd0: v = 16'd0;
                5'd1: v = 16'd3212;
                5'd2: v = 16'd6393;
                5'd3: v = 16'd9512;
                5'd4: v = 16'd12540;
                5'd5: v = 16'd15447;
                5'd6: v = 16'd18205;
                5'd7: v = 16'd20788;
                5'd8: v = 16'd23170;
                5'd9: v = 16'd25330;
                5'd10: v = 16'd27246;
                5'd11: v = 16'd28899;
                5'd12: v = 16'd30274;
                5'd13: v = 16'd31357;
                5'd14: v = 16'd32138;
                5'd15: v = 16'd32610;
                5'd16: v = 16'd32767;
                default: v = 16'd0;
            endcase
            return v;
        end
    endfunction

    // cos and sin of 2*pi*k/64 as signed 17 bit
    function automatic logic signed [16:0] rom_cos(input logic [4:0] k);
        logic signed [16:0] v;
        begin
            if (k <= 5'd16) v = $signed({1'b0, qsin(5'd16 - k)});
            else v = -$signed({1'b0, qsin(k - 5'd16)});
            return v;
        end
    endfunction

    function automatic logic signed [16:0] rom_sin(input logic [4:0] k);
        logic signed [16:0] v;
        begin
            if (k <= 5'd16) v = $signed({1'b0, qsin(k)});
            else v = $signed({1'b0, qsin(5'd0 - k)});
            return v;
        end
    endfunction

    function automatic logic signed [BinW-1:0] sat23(input logic signed [BinW+1:0] v);
        logic signed [BinW-1:0] r;
        begin
            if (v > $signed({{2{1'b0}}, SAT_MAX})) r = SAT_MAX;
            else if (v < $signed({{2{1'b1}}, SAT_MIN})) r = SAT_MIN;
            else r = v[BinW-1:0];
            return r;
        end
    endfunction

    function automatic logic is_clip(input logic signed [BinW+1:0] v);
        return (v > $signed({{2{1'b0}}, SAT_MAX})) || (v < $signed({{2{1'b1}}, SAT_MIN}));
    endfunction

endpackage

// ===== design/r2fft_front.sv =====
// front part: takes sample beats, counts the frame, queues samples for the back
// depends on r2fft_pkg
module r2fft_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [0:0]                     cfg_index,
    input  logic [r2fft_pkg::CfgW-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [r2fft_pkg::SampleW-1:0]  in_re,
    input  logic [r2fft_pkg::SampleW-1:0]  in_im,
    output logic                           q_valid,
    input  logic                           q_ready,
    output r2fft_pkg::smp_t                q_data
);
    import r2fft_pkg::*;

    logic [2:0] log2_reg;
    logic       inv_reg;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [2:0] lg;
    logic [CntW-1:0] npts;
    logic       full;

    // two entry queue
    smp_t q_mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] fill_reg;
    logic       push, pop;

    always_comb begin
        lg = log2_reg;
        if (lg == 3'd0) lg = 3'd1;
        if (lg > 3'(MaxLog2)) lg = 3'(MaxLog2);
        npts = CntW'(1) << lg;
    end

    assign in_ready = (fill_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign q_valid = (fill_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_data = q_mem[rp_reg];
    assign cnt_next = cnt_reg + CntW'(1);
    assign full = (cnt_next >= npts);

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wp_reg] <= '{re: in_re, im: in_im, last: full, lg: lg, inv: inv_reg};
        end
        if (!aresetn) begin
            log2_reg <= 3'd6;
            inv_reg  <= 1'b0;
            cnt_reg  <= '0;
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_LOG2_POINTS: log2_reg <= cfg_data;
                    CFG_INVERSE:     inv_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
            if (push) begin
                cnt_reg <= full ? '0 : cnt_next;
                wp_reg  <= ~wp_reg;
            end
            if (pop) rp_reg <= ~rp_reg;
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ===== design/r2fft_back.sv =====
// back part: frame memory, butterfly sequencer and bin unload
// depends on r2fft_pkg
module r2fft_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  r2fft_pkg::smp_t               q_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [r2fft_pkg::BinW-1:0]    out_re,
    output logic [r2fft_pkg::BinW-1:0]    out_im,
    output logic [r2fft_pkg::AddrW-1:0]   out_idx,
    output logic                          out_last,
    output logic                          out_sat
);
    import r2fft_pkg::*;

    typedef enum logic [6:0] {
        S_LOAD = 7'b0000001,
        S_PRD  = 7'b0000010,
        S_PWR  = 7'b0000100,
        S_RDA  = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_WR   = 7'b0100000,
        S_OUT  = 7'b1000000
    } st_t;

    st_t st_reg;
    logic [2*BinW-1:0] mem [MaxPoints];
    logic [AddrW-1:0] ld_reg;
    logic [2:0] lg_reg;
    logic inv_reg, clip_reg;
    logic [2:0] stg_reg;
    logic [AddrW-1:0] g_reg, p_reg;
    logic [AddrW-1:0] oi_reg;
    logic [2*BinW-1:0] a_reg, x_reg;
    logic signed [BinW:0] pr_reg, pi_reg;
    logic [AddrW-1:0] pa, qa, step, lgmask, rev_p;
    logic [4:0] k;
    logic signed [16:0] wc, ws;
    logic signed [BinW-1:0] ar, ai, xr, xi;
    logic signed [BinW+17:0] mr, mi;
    logic signed [BinW+1:0] sr0, si0, sr1, si1;
    logic bf_last;
    logic ob_valid_reg, out_free;
    logic [AddrW-1:0] next_p;
    logic [AddrW:0] p_adv;

    assign step = AddrW'(1) << stg_reg;
    assign lgmask = AddrW'((7'd1 << lg_reg) - 7'd1);
    assign pa = p_reg;
    assign qa = p_reg + step;
    assign k = 5'((11'(g_reg) << 5) >> stg_reg);

    // bit reversed partner of p_reg over the frame length
    always_comb begin
        rev_p = '0;
        for (int b = 0; b < AddrW; b++) begin
            if (b < int'(lg_reg)) rev_p[lg_reg - 3'd1 - 3'(b)] = p_reg[b];
        end
    end

    always_comb begin
        wc = rom_cos(k);
        ws = inv_reg ? rom_sin(k) : -rom_sin(k);
        ar = $signed(a_reg[2*BinW-1:BinW]);
        ai = $signed(a_reg[BinW-1:0]);
        xr = $signed(x_reg[2*BinW-1:BinW]);
        xi = $signed(x_reg[BinW-1:0]);
        mr = wc * xr - ws * xi + 41'sd16384;
        mi = wc * xi + ws * xr + 41'sd16384;
        sr0 = 25'(ar) + 25'(pr_reg);
        si0 = 25'(ai) + 25'(pi_reg);
        sr1 = 25'(ar) - 25'(pr_reg);
        si1 = 25'(ai) - 25'(pi_reg);
        p_adv = {1'b0, p_reg} + {step, 1'b0};
        if (p_adv > {1'b0, lgmask}) begin
            next_p = g_reg + AddrW'(1);
            bf_last = (g_reg + AddrW'(1) == step);
        end else begin
            next_p = p_adv[AddrW-1:0];
            bf_last = 1'b0;
        end
    end

    assign q_ready = (st_reg == S_LOAD);
    assign out_free = !ob_valid_reg || out_ready;
    assign out_valid = ob_valid_reg;

    always_ff @(posedge aclk) begin
        case (st_reg)
            S_LOAD: if (q_valid) mem[ld_reg] <=
                {BinW'(q_data.re), BinW'(q_data.im)};
            S_PRD: begin
                a_reg <= mem[pa];
                x_reg <= mem[rev_p];
            end
            S_PWR: if (rev_p > p_reg) begin
                mem[pa]    <= x_reg;
                mem[rev_p] <= a_reg;
            end
            S_RDA: begin
                a_reg <= mem[pa];
                x_reg <= mem[qa];
            end
            S_MUL: begin
                if (k == 5'd0) begin
                    pr_reg <= (BinW+1)'(xr);
                    pi_reg <= (BinW+1)'(xi);
                end else begin
                    pr_reg <= (BinW+1)'(mr >>> 15);
                    pi_reg <= (BinW+1)'(mi >>> 15);
                end
            end
            S_WR: begin
                mem[pa] <= {sat23(sr0), sat23(si0)};
                mem[qa] <= {sat23(sr1), sat23(si1)};
            end
            S_OUT: if (out_free) begin
                out_re  <= mem[oi_reg][2*BinW-1:BinW];
                out_im  <= mem[oi_reg][BinW-1:0];
                out_idx <= oi_reg;
                out_last <= (oi_reg == lgmask);
                out_sat <= clip_reg;
            end
            default: ;
        endcase
        if (!aresetn) begin
            st_reg <= S_LOAD;
            ld_reg <= '0;
            lg_reg <= 3'd6;
            inv_reg <= 1'b0;
            clip_reg <= 1'b0;
            stg_reg <= '0;
            g_reg <= '0;
            p_reg <= '0;
            oi_reg <= '0;
            ob_valid_reg <= 1'b0;
        end else begin
            if (out_ready) ob_valid_reg <= 1'b0;
            unique case (st_reg)
                S_LOAD: if (q_valid) begin
                    ld_reg <= q_data.last ? '0 : ld_reg + AddrW'(1);
                    if (q_data.last) begin
                        lg_reg <= q_data.lg;
                        inv_reg <= q_data.inv;
                        stg_reg <= '0;
                        g_reg <= '0;
                        p_reg <= '0;
                        st_reg <= S_PRD;
                    end
                end
                S_PRD: st_reg <= S_PWR;
                S_PWR: begin
                    if (p_reg == lgmask) begin
                        p_reg <= '0;
                        st_reg <= S_RDA;
                    end else begin
                        p_reg <= p_reg + AddrW'(1);
                        st_reg <= S_PRD;
                    end
                end
                S_RDA: st_reg <= S_MUL;
                S_MUL: st_reg <= S_WR;
                S_WR: begin
                    if (is_clip(sr0) || is_clip(si0) || is_clip(sr1) || is_clip(si1))
                        clip_reg <= 1'b1;
                    p_reg <= next_p;
                    st_reg <= S_RDA;
                    if (bf_last) begin
                        g_reg <= '0;
                        p_reg <= '0;
                        stg_reg <= stg_reg + 3'd1;
                        if (stg_reg + 3'd1 == lg_reg) begin
                            oi_reg <= '0;
                            st_reg <= S_OUT;
                        end
                    end else if (p_adv > {1'b0, lgmask}) begin
                        g_reg <= g_reg + AddrW'(1);
                    end
                end
                S_OUT: if (out_free) begin
                    ob_valid_reg <= 1'b1;
                    oi_reg <= oi_reg + AddrW'(1);
                    if (oi_reg == lgmask) begin
                        clip_reg <= 1'b0;
                        st_reg <= S_LOAD;
                    end
                end
                default: st_reg <= S_LOAD;
            endcase
        end
    end
endmodule

// ===== design/radix2_fft_engine_unit.sv =====
// top level of the radix-2 decimation-in-time fft engine
// depends on r2fft_pkg, r2fft_front, r2fft_back
//
// channel   dir  payload
// s_axis    in   tdata = sample_real[15:0], sample_imag[31:16]
// m_axis    out  tdata = bin_real, bin_imag, bin_index; tlast = last_bin; tuser = saturated
// cfg       in   index 0 log2_points, index 1 inverse
//
// samples are stored in arrival order; an in-place bit reversal pass then reads
// each point and its partner in a read state and swaps the pair in a write state;
// an n point frame then needs (n/2)*log2(n) butterflies, each stepping through a
// read, a multiply and a write state in the single shared butterfly unit; the bins
// are then unloaded in index order
// aresetn is synchronous, active low; config resets to 64 points, forward
// a two beat queue sits between the sample front and the transform back; while
// the back transforms or unloads, the queue fills and s_tready drops
module radix2_fft_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [2:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample_real, sample_imag
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // bin_real, bin_imag, bin_index, zero pad
    output logic        m_tlast,   // last_bin
    output logic        m_tuser    // saturated
);
    import r2fft_pkg::*;

    smp_t q_data;
    logic q_valid, q_ready;
    logic [BinW-1:0] ore, oim;
    logic [AddrW-1:0] oidx;

    // sample intake and frame counting
    r2fft_front u_front (
        .aclk, .aresetn, .cfg_wr_en, .cfg_index, .cfg_data,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_re(s_tdata[15:0]), .in_im(s_tdata[31:16]),
        .q_valid, .q_ready, .q_data
    );

    // frame store, bit reversal, butterflies and bin unload
    r2fft_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_data,
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_re(ore), .out_im(oim), .out_idx(oidx),
        .out_last(m_tlast), .out_sat(m_tuser)
    );

    assign m_tdata = {4'd0, oidx, oim, ore};
endmodule

// ===== design/r2fft_checker.sv =====
// port level checks for the fft engine
// bound to radix2_fft_engine_unit
module r2fft_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");
    a_idx0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid || m_tdata[51:46] == 6'd0
        || !$past(m_tvalid))
        else $error("new frame did not start at bin zero");
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast ##1 m_tvalid |->
        m_tdata[51:46] == $past(m_tdata[51:46]) + 6'd1)
        else $error("bin index skipped");
endmodule

bind radix2_fft_engine_unit r2fft_checker u_chk (.*);

// ===== tb/tb_radix2_fft_engine_unit.sv =====
// self-checking testbench for the radix-2 fft engine: random sample beats,
// a bit-exact fft predictor in a small scoreboard class, random stalls on both sides
// depends on r2fft_pkg and radix2_fft_engine_unit
module tb_radix2_fft_engine_unit;
    import r2fft_pkg::*;

    // one expected output bin
    typedef struct {
        logic signed [BinW-1:0] re;
        logic signed [BinW-1:0] im;
        logic [AddrW-1:0]       idx;
        logic                   last;
        logic                   sat;
    } bin_t;

    // fft predictor and store of expected bins
    class fft_scoreboard;
        longint buf_re[64];
        longint buf_im[64];
        int     loaded;
        bit     clipped;
        int     lg_reg;
        int     inv_reg;
        int     errors;
        bin_t   bins_q[$];
        int     sine_tab[17] = '{0, 3212, 6393, 9512, 12540, 15447, 18205, 20788,
                                 23170, 25330, 27246, 28899, 30274, 31357, 32138,
                                 32610, 32767};

        function new();
            loaded = 0;
            clipped = 0;
            lg_reg = 6;
            inv_reg = 0;
            errors = 0;
            foreach (buf_re[i]) begin
                buf_re[i] = 0;
                buf_im[i] = 0;
            end
        endfunction

        function void write_reg(logic [0:0] idx, logic [CfgW-1:0] val);
            if (idx == CFG_LOG2_POINTS) lg_reg = val;
            else inv_reg = val[0];
        endfunction

        function longint clip23(longint v);
            if (v > 4194303) begin
                clipped = 1;
                return 4194303;
            end
            if (v < -4194304) begin
                clipped = 1;
                return -4194304;
            end
            return v;
        endfunction

        function void run_fft(int lg);
            int n;
            int r;
            int k;
            int q;
            longint wc, ws, xr, xi, pr, pi, ar, ai, t;
            n = 1 << lg;
            // bit reversal permutation
            for (int i = 0; i < n; i++) begin
                r = 0;
                for (int b = 0; b < lg; b++) r |= ((i >> b) & 1) << (lg - 1 - b);
                if (r > i) begin
                    t = buf_re[i]; buf_re[i] = buf_re[r]; buf_re[r] = t;
                    t = buf_im[i]; buf_im[i] = buf_im[r]; buf_im[r] = t;
                end
            end
            for (int step = 1; step < n; step <<= 1) begin
                for (int g = 0; g < step; g++) begin
                    k = (g * 32 / step) & 31;
                    if (k <= 16) begin
                        wc = sine_tab[16 - k];
                        ws = sine_tab[k];
                    end else begin
                        wc = -sine_tab[k - 16];
                        ws = sine_tab[32 - k];
                    end
                    if (inv_reg == 0) ws = -ws;
                    for (int p = g; p < n; p += step << 1) begin
                        q = (p + step) & 63;
                        xr = buf_re[q];
                        xi = buf_im[q];
                        // zero angle skips the multiplier
                        if (k == 0) begin
                            pr = xr;
                            pi = xi;
                        end else begin
                            pr = (wc * xr - ws * xi + 16384) >>> 15;
                            pi = (wc * xi + ws * xr + 16384) >>> 15;
                        end
                        ar = buf_re[p];
                        ai = buf_im[p];
                        buf_re[q] = clip23(ar - pr);
                        buf_im[q] = clip23(ai - pi);
                        buf_re[p] = clip23(ar + pr);
                        buf_im[p] = clip23(ai + pi);
                    end
                end
            end
        endfunction

        // note one accepted sample beat
        function void note_sample(logic signed [15:0] re, logic signed [15:0] im);
            int lg;
            int n;
            bin_t b;
            lg = lg_reg;
            if (lg < 1) lg = 1;
            if (lg > MaxLog2) lg = MaxLog2;
            n = 1 << lg;
            buf_re[loaded & 63] = re;
            buf_im[loaded & 63] = im;
            loaded = (loaded + 1) & 127;
            if (loaded < n) return;
            run_fft(lg);
            for (int i = 0; i < n; i++) begin
                b.re = BinW'(buf_re[i]);
                b.im = BinW'(buf_im[i]);
                b.idx = AddrW'(i);
                b.last = (i == n - 1);
                b.sat = clipped;
                bins_q.push_back(b);
            end
            loaded = 0;
            clipped = 0;
        endfunction

        // compare one accepted bin beat with the oldest expectation
        function void check_bin(logic [BinW-1:0] re, logic [BinW-1:0] im,
                                logic [AddrW-1:0] idx, logic last, logic sat);
            bin_t b;
            if (bins_q.size() == 0) begin
                $display("%0t: unexpected bin beat re=%0d im=%0d idx=%0d",
                         $time, $signed(re), $signed(im), idx);
                errors++;
                return;
            end
            b = bins_q.pop_front();
            if (re !== b.re) begin
                $display("%0t: bin_real expected %0d actual %0d", $time, b.re, $signed(re));
                errors++;
            end
            if (im !== b.im) begin
                $display("%0t: bin_imag expected %0d actual %0d", $time, b.im, $signed(im));
                errors++;
            end
            if (idx !== b.idx) begin
                $display("%0t: bin_index expected %0d actual %0d", $time, b.idx, idx);
                errors++;
            end
            if (last !== b.last) begin
                $display("%0t: last_bin expected %0d actual %0d", $time, b.last, last);
                errors++;
            end
            if (sat !== b.sat) begin
                $display("%0t: saturated expected %0d actual %0d", $time, b.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [0:0]  cfg_index;
    logic [2:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // sample_real, sample_imag
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;    // bin_real, bin_imag, bin_index, zero pad
    logic        m_tlast;    // last_bin
    logic        m_tuser;    // saturated

    fft_scoreboard sb;
    bit  send_calm;      // sender offers every cycle
    bit  recv_calm;      // receiver always ready
    bit  hold_req;       // ask the receiver for a long hold-off
    int  items_sent;

    radix2_fft_engine_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // offer one sample beat, sometimes with a random gap in front of it
    task automatic send_sample(logic [15:0] re, logic [15:0] im);
        if (!send_calm && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {im, re};
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(re, im);
        items_sent++;
    endtask

    // pause the sender until every expected bin has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.bins_q.size() != 0) @(posedge aclk);
        // queued samples that make no bin may still be in flight
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [2:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic send_random_frame(int n);
        logic [15:0] re, im;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: begin
                    re = 16'($urandom);
                    im = 16'($urandom);
                end
                1: begin
                    // near full scale to stress growth
                    re = $urandom_range(0, 1) ? 16'(16'h7fff - $urandom_range(0, 7))
                                              : 16'(16'h8000 + $urandom_range(0, 7));
                    im = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                end
                default: begin
                    re = 16'($urandom_range(0, 400) - 200);
                    im = 16'($urandom_range(0, 400) - 200);
                end
            endcase
            send_sample(re, im);
        end
    endtask

    // receiver: random ready, calm stretches, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
                hold_req = 0;
            end else begin
                m_tready <= recv_calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // bin beat checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_bin(m_tdata[22:0], m_tdata[45:23], m_tdata[51:46], m_tlast, m_tuser);
    end

    initial begin
        #40000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int lg;
        sb = new();
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        send_calm = 0;
        recv_calm = 0;
        hold_req = 0;
        items_sent = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: two point forward with full-scale extremes
        write_reg(CFG_LOG2_POINTS, 3'd1);
        send_sample(16'h7fff, 16'h8000);
        send_sample(16'h8000, 16'h7fff);
        send_sample(16'h0000, 16'hffff);
        send_sample(16'hffff, 16'h0000);
        // four point inverse
        write_reg(CFG_LOG2_POINTS, 3'd2);
        write_reg(CFG_INVERSE, 3'd1);
        send_sample(16'h7fff, 16'h7fff);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h1234, 16'hedcb);
        send_sample(16'h0001, 16'h0000);
        // length zero acts as two points
        write_reg(CFG_LOG2_POINTS, 3'd0);
        send_sample(16'h4000, 16'hc000);
        send_sample(16'h7fff, 16'h8000);
        // length seven acts as 64 points; length shrunk mid-frame
        write_reg(CFG_LOG2_POINTS, 3'd7);
        write_reg(CFG_INVERSE, 3'd0);
        send_random_frame(5);
        write_reg(CFG_LOG2_POINTS, 3'd2);
        send_random_frame(1);
        send_random_frame(4);
        drain();

        // long receiver hold-off while the sender keeps offering
        write_reg(CFG_LOG2_POINTS, 3'd2);
        send_calm = 1;
        hold_req = 1;
        send_random_frame(24);
        send_calm = 0;
        drain();

        // a full size frame without idling on either side
        write_reg(CFG_LOG2_POINTS, 3'd6);
        send_calm = 1;
        recv_calm = 1;
        send_random_frame(64);
        send_calm = 0;
        recv_calm = 0;

        // random phases, mostly small frames
        while (items_sent < 160) begin
            lg = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
            write_reg(CFG_LOG2_POINTS, 3'(lg));
            write_reg(CFG_INVERSE, 3'($urandom_range(0, 1)));
            send_random_frame((1 << lg) * $urandom_range(1, 3));
        end
        write_reg(CFG_LOG2_POINTS, 3'd3);
        write_reg(CFG_INVERSE, 3'd1);
        send_random_frame(16);

        s_tvalid <= 1'b0;
        while (sb.bins_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
